### rtl/pixel_to_bgra_with_mirror_address_macros.svh
// assertion macros shared by the pixel to bgra rtl
// no dependencies; included by the files that carry assertions
`ifndef PIXEL_TO_BGRA_WITH_MIRROR_ADDRESS_MACROS_SVH
`define PIXEL_TO_BGRA_WITH_MIRROR_ADDRESS_MACROS_SVH

// checked on every clock edge outside reset
`define PTBGRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define PTBGRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/ptbgra_pkg.sv
// types and constants for the pixel to bgra converter with mirrored address
// no dependencies
package ptbgra_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int CHANNEL_WIDTH  = 8;
   localparam int SIZE_WIDTH     = 13;
   localparam int ADDR_WIDTH     = 12;
   localparam int CSR_DATA_WIDTH = 13;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int REQ_DATA_WIDTH = 4 * CHANNEL_WIDTH;
   localparam int RSP_DATA_WIDTH = 4 * CHANNEL_WIDTH + 2 * ADDR_WIDTH;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHANNEL_WIDTH-1:0] OPAQUE_ALPHA = 8'd255;

   // bits of the format and flip codes
   localparam int FMT_BLUE_FIRST_BIT = 0;
   localparam int FMT_HAS_ALPHA_BIT  = 1;
   localparam int FLIP_HORIZ_BIT     = 0;
   localparam int FLIP_VERT_BIT      = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PIXELS_PER_ROW = 2'd0,
      CSR_ROWS_PER_FRAME = 2'd1,
      CSR_SOURCE_FORMAT  = 2'd2,
      CSR_FLIP_MODE      = 2'd3
   } ptbgra_csr_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0] pixels_per_row;
      logic [SIZE_WIDTH-1:0] rows_per_frame;
      logic [1:0]            source_format;
      logic [1:0]            flip_mode;
   } ptbgra_cfg_type;

   typedef struct packed {
      logic [1:0]               source_format;
      logic [CHANNEL_WIDTH-1:0] fourth_channel;
      logic [CHANNEL_WIDTH-1:0] third_channel;
      logic [CHANNEL_WIDTH-1:0] second_channel;
      logic [CHANNEL_WIDTH-1:0] first_channel;
      logic [ADDR_WIDTH-1:0]    dest_column;
      logic [ADDR_WIDTH-1:0]    dest_row;
      logic                     frame_end;
   } ptbgra_entry_type;

endpackage

### rtl/ptbgra_front.sv
// front end: accepts source pixels, tracks raster position, mirrors the address
// depends on ptbgra_pkg and the assertion macro header
`include "pixel_to_bgra_with_mirror_address_macros.svh"

module ptbgra_front #(
   parameter int MAX_WIDTH  = ptbgra_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ptbgra_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ptbgra_pkg::ptbgra_cfg_type             cfg,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ptbgra_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic                                   queue_full,
   output logic                                   queue_push,
   output ptbgra_pkg::ptbgra_entry_type           queue_entry
);
   import ptbgra_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0] column_count_ff, column_count_in;
   logic [RW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] w_m1, col, dcol;
   logic [RW-1:0] h_m1, row, drow;
   logic          last_col, last_row;

   always_comb begin
      if (cfg.pixels_per_row == '0) begin
         w_m1 = '0;
      end else if (32'(cfg.pixels_per_row) > 32'(MAX_WIDTH)) begin
         w_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         w_m1 = CW'(cfg.pixels_per_row - 13'd1);
      end
      if (cfg.rows_per_frame == '0) begin
         h_m1 = '0;
      end else if (32'(cfg.rows_per_frame) > 32'(MAX_HEIGHT)) begin
         h_m1 = RW'(MAX_HEIGHT - 1);
      end else begin
         h_m1 = RW'(cfg.rows_per_frame - 13'd1);
      end
   end

   always_comb begin
      col      = (column_count_ff <= w_m1) ? column_count_ff : w_m1;
      row      = (row_count_ff <= h_m1) ? row_count_ff : h_m1;
      last_col = (col == w_m1);
      last_row = (row == h_m1);
      dcol     = cfg.flip_mode[FLIP_HORIZ_BIT] ? (w_m1 - col) : col;
      drow     = cfg.flip_mode[FLIP_VERT_BIT] ? (h_m1 - row) : row;
      if (last_col) begin
         column_count_in = '0;
         row_count_in    = last_row ? '0 : (row + RW'(1));
      end else begin
         column_count_in = col + CW'(1);
         row_count_in    = row;
      end
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

   always_comb begin
      queue_entry.source_format  = cfg.source_format;
      queue_entry.first_channel  = req_tdata[CHANNEL_WIDTH-1:0];
      queue_entry.second_channel = req_tdata[2*CHANNEL_WIDTH-1:CHANNEL_WIDTH];
      queue_entry.third_channel  = req_tdata[3*CHANNEL_WIDTH-1:2*CHANNEL_WIDTH];
      queue_entry.fourth_channel = req_tdata[4*CHANNEL_WIDTH-1:3*CHANNEL_WIDTH];
      queue_entry.dest_column    = ADDR_WIDTH'(dcol);
      queue_entry.dest_row       = ADDR_WIDTH'(drow);
      queue_entry.frame_end      = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else if (queue_push) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   `PTBGRA_ASSERT(a_column_in_range, clock, reset, queue_push |=> column_count_ff <= $past(w_m1), "column counter beyond width")
   `PTBGRA_ASSERT(a_row_in_range, clock, reset, queue_push |=> row_count_ff <= $past(h_m1), "row counter beyond height")
   `PTBGRA_ASSERT(a_push_needs_item, clock, reset, queue_push |-> req_tvalid && req_tready, "push without an accepted item")

endmodule

### rtl/ptbgra_queue.sv
// short queue between the front end and the back end
// depends on ptbgra_pkg and the assertion macro header
`include "pixel_to_bgra_with_mirror_address_macros.svh"

module ptbgra_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ptbgra_pkg::ptbgra_entry_type push_entry,
   output logic                         full,
   input  logic                         pop,
   output logic                         pop_valid,
   output ptbgra_pkg::ptbgra_entry_type pop_entry
);
   import ptbgra_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ptbgra_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (wr_ptr_ff + PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (rd_ptr_ff + PTR_W'(1));
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `PTBGRA_ASSERT(a_no_push_when_full, clock, reset, !(push && full), "item pushed into a full queue")
   `PTBGRA_ASSERT(a_no_pop_when_empty, clock, reset, !(pop && !pop_valid), "item popped from an empty queue")
   `PTBGRA_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_W'(QUEUE_DEPTH)), "queue count beyond depth")

endmodule

### rtl/ptbgra_back.sv
// back end: swizzles channels into bgra and holds the result register
// depends on ptbgra_pkg
module ptbgra_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   queue_valid,
   input  ptbgra_pkg::ptbgra_entry_type           queue_entry,
   output logic                                   queue_pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ptbgra_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                   rsp_tlast
);
   import ptbgra_pkg::*;

   logic                      valid_ff;
   logic [RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic                      last_ff;
   logic [CHANNEL_WIDTH-1:0]  blue, red, alpha;

   always_comb begin
      if (queue_entry.source_format[FMT_BLUE_FIRST_BIT]) begin
         blue = queue_entry.first_channel;
         red  = queue_entry.third_channel;
      end else begin
         blue = queue_entry.third_channel;
         red  = queue_entry.first_channel;
      end
      alpha   = queue_entry.source_format[FMT_HAS_ALPHA_BIT] ?
                queue_entry.fourth_channel : OPAQUE_ALPHA;
      data_in = {queue_entry.dest_row, queue_entry.dest_column,
                 alpha, red, queue_entry.second_channel, blue};
   end

   assign queue_pop  = queue_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (queue_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         data_ff <= data_in;
         last_ff <= queue_entry.frame_end;
      end
   end

endmodule

### rtl/pixel_to_bgra_with_mirror_address.sv
// Pixel format converter: takes source pixels in raster order and gives one BGRA
// pixel per item with its destination column and row, mirrored by flip_mode, and
// tlast on the last pixel of a frame. One item per clock is sustained while
// rsp_tready is high; an item goes through the front end into the queue, then
// into the result register. A two-entry queue buffers req while rsp is stalled.
// Users write registers via the csr port with no item in flight (not enforced).
// top level; depends on ptbgra_pkg, ptbgra_front, ptbgra_queue and ptbgra_back
module pixel_to_bgra_with_mirror_address #(
   parameter int MAX_WIDTH  = ptbgra_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ptbgra_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ptbgra_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ptbgra_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // first_channel, second_channel, third_channel, fourth_channel
   input  logic [ptbgra_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_blue, out_green, out_red, out_alpha, dest_column, dest_row
   output logic [ptbgra_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                   rsp_tlast
);
   import ptbgra_pkg::*;

   ptbgra_cfg_type   cfg_ff;
   ptbgra_entry_type push_entry, pop_entry;
   logic             queue_full, queue_push, queue_pop, queue_valid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixels_per_row <= SIZE_WIDTH'(1);
         cfg_ff.rows_per_frame <= SIZE_WIDTH'(1);
         cfg_ff.source_format  <= '0;
         cfg_ff.flip_mode      <= '0;
      end else if (csr_valid) begin
         unique case (ptbgra_csr_type'(csr_index))
            CSR_PIXELS_PER_ROW: cfg_ff.pixels_per_row <= csr_data[SIZE_WIDTH-1:0];
            CSR_ROWS_PER_FRAME: cfg_ff.rows_per_frame <= csr_data[SIZE_WIDTH-1:0];
            CSR_SOURCE_FORMAT:  cfg_ff.source_format  <= csr_data[1:0];
            CSR_FLIP_MODE:      cfg_ff.flip_mode      <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   ptbgra_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   ptbgra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_entry  (pop_entry)
   );

   ptbgra_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_entry (pop_entry),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
